// ===== rtl/core/skt_pkg.sv =====
// sorted key table package: widths, default parameters, action and status codes
// no dependencies; used by scoped names by every file of the block but skt_ram

package skt_pkg;

    localparam int KEY_W        = 32;
    localparam int DEPTH_DEF    = 64;
    localparam int HANDLE_W_DEF = 32;
    localparam int ACT_W        = 2;
    localparam int STATUS_W     = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_FETCH  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_GET    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_DUP   = 3'd1,
        STAT_MISS  = 3'd2,
        STAT_RANGE = 3'd3,
        STAT_FULL  = 3'd4
    } status_t;

    // result strobe and status, from the sequencer to the output stage
    typedef struct packed {
        logic    valid;
        status_t status;
    } res_ctl_t;

endpackage

// ===== rtl/core/skt_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/skt_ctrl.sv =====
// sorted key table sequencer: binary search, probe and entry shifting over the ram
// depends on skt_pkg; drives the read and write ports of one skt_ram instance

module skt_ctrl #(
    parameter int DEPTH        = skt_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = skt_pkg::HANDLE_W_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int EW = skt_pkg::KEY_W + HANDLE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // item in
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [skt_pkg::ACT_W-1:0]      in_action,
    input  logic signed [skt_pkg::KEY_W-1:0] in_key,
    input  logic [HANDLE_WIDTH-1:0]        in_handle,
    input  logic [AW-1:0]                  in_index,
    // result out
    output skt_pkg::res_ctl_t              res_ctl,
    output logic [HANDLE_WIDTH-1:0]        res_handle,
    output logic signed [skt_pkg::KEY_W-1:0] res_key,
    output logic [CW-1:0]                  res_pos,
    output logic [CW-1:0]                  res_count,
    input  logic                           res_free,
    // ram ports
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [EW-1:0]                  wr_data,
    output logic [AW-1:0]                  rd_addr,
    input  logic [EW-1:0]                  rd_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_CMP    = 9'b000000100,
        S_PROBE  = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_SHUP   = 9'b000100000,
        S_PUT    = 9'b001000000,
        S_SHDN   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    skt_pkg::action_t act_reg, act_next;
    logic signed [skt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [HANDLE_WIDTH-1:0] hdl_reg, hdl_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] j_reg, j_next;
    logic [CW-1:0] count_reg, count_next;
    logic hit_reg, hit_next;
    logic signed [skt_pkg::KEY_W-1:0] ent_key_reg, ent_key_next;
    logic [HANDLE_WIDTH-1:0] ent_hdl_reg, ent_hdl_next;
    skt_pkg::status_t status_reg, status_next;
    logic signed [skt_pkg::KEY_W-1:0] out_key_reg, out_key_next;
    logic [HANDLE_WIDTH-1:0] out_hdl_reg, out_hdl_next;
    logic [CW-1:0] pos_reg, pos_next;

    logic signed [skt_pkg::KEY_W-1:0] rd_key;
    logic [HANDLE_WIDTH-1:0] rd_hdl;
    logic [CW-1:0] mid;

    assign rd_key = $signed(rd_data[EW-1:HANDLE_WIDTH]);
    assign rd_hdl = rd_data[HANDLE_WIDTH-1:0];
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        hdl_next     = hdl_reg;
        idx_next     = idx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        ent_key_next = ent_key_reg;
        ent_hdl_next = ent_hdl_reg;
        status_next  = status_reg;
        out_key_next = out_key_reg;
        out_hdl_next = out_hdl_reg;
        pos_next     = pos_reg;
        rd_addr      = j_reg;
        wr_en        = 1'b0;
        wr_addr      = j_reg;
        wr_data      = rd_data;
        res_ctl.valid  = 1'b0;
        res_ctl.status = status_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    act_next = skt_pkg::action_t'(in_action);
                    key_next = in_key;
                    hdl_next = in_handle;
                    idx_next = in_index;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    if (skt_pkg::action_t'(in_action) == skt_pkg::ACT_GET) begin
                        if (CW'(in_index) < count_reg) begin
                            rd_addr    = in_index;
                            state_next = S_PROBE;
                        end else begin
                            status_next  = skt_pkg::STAT_RANGE;
                            out_key_next = '0;
                            out_hdl_next = '0;
                            pos_next     = '0;
                            state_next   = S_DONE;
                        end
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    rd_addr    = mid[AW-1:0];
                    state_next = S_CMP;
                end else if (lo_reg < count_reg) begin
                    rd_addr    = lo_reg[AW-1:0];
                    state_next = S_PROBE;
                end else begin
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_CMP: begin
                if (rd_key < key_reg) begin
                    lo_next = mid + CW'(1);
                end else begin
                    hi_next = mid;
                end
                state_next = S_SEARCH;
            end
            S_PROBE: begin
                hit_next     = (rd_key == key_reg);
                ent_key_next = rd_key;
                ent_hdl_next = rd_hdl;
                state_next   = S_DECIDE;
            end
            S_DECIDE: begin
                pos_next     = lo_reg;
                status_next  = skt_pkg::STAT_OK;
                out_key_next = ent_key_reg;
                out_hdl_next = ent_hdl_reg;
                state_next   = S_DONE;
                case (act_reg)
                    skt_pkg::ACT_GET: begin
                        pos_next = CW'(idx_reg);
                    end
                    skt_pkg::ACT_INSERT: begin
                        out_key_next = '0;
                        out_hdl_next = '0;
                        if (hit_reg) begin
                            status_next = skt_pkg::STAT_DUP;
                        end else if (count_reg >= CW'(DEPTH)) begin
                            status_next = skt_pkg::STAT_FULL;
                        end else if (count_reg > lo_reg) begin
                            // open a gap: move entries up from the top down
                            j_next     = AW'(count_reg - CW'(1));
                            rd_addr    = AW'(count_reg - CW'(1));
                            state_next = S_SHUP;
                        end else begin
                            state_next = S_PUT;
                        end
                    end
                    default: begin
                        // fetch and remove
                        if (!hit_reg) begin
                            status_next  = skt_pkg::STAT_MISS;
                            out_key_next = '0;
                            out_hdl_next = '0;
                        end else if (act_reg == skt_pkg::ACT_REMOVE) begin
                            if (lo_reg + CW'(1) < count_reg) begin
                                // close the gap: move entries down from the bottom up
                                j_next     = AW'(lo_reg + CW'(1));
                                rd_addr    = AW'(lo_reg + CW'(1));
                                state_next = S_SHDN;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                endcase
            end
            S_SHUP: begin
                wr_en   = 1'b1;
                wr_addr = j_reg + AW'(1);
                wr_data = rd_data;
                if (CW'(j_reg) == lo_reg) begin
                    state_next = S_PUT;
                end else begin
                    j_next  = j_reg - AW'(1);
                    rd_addr = j_reg - AW'(1);
                end
            end
            S_PUT: begin
                wr_en        = 1'b1;
                wr_addr      = lo_reg[AW-1:0];
                wr_data      = {key_reg, hdl_reg};
                count_next   = count_reg + CW'(1);
                status_next  = skt_pkg::STAT_OK;
                out_key_next = key_reg;
                out_hdl_next = hdl_reg;
                state_next   = S_DONE;
            end
            S_SHDN: begin
                wr_en   = 1'b1;
                wr_addr = j_reg - AW'(1);
                wr_data = rd_data;
                if (CW'(j_reg) == count_reg - CW'(1)) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end else begin
                    j_next  = j_reg + AW'(1);
                    rd_addr = j_reg + AW'(1);
                end
            end
            S_DONE: begin
                if (res_free) begin
                    res_ctl.valid = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        act_reg     <= act_next;
        key_reg     <= key_next;
        hdl_reg     <= hdl_next;
        idx_reg     <= idx_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        j_reg       <= j_next;
        hit_reg     <= hit_next;
        ent_key_reg <= ent_key_next;
        ent_hdl_reg <= ent_hdl_next;
        status_reg  <= status_next;
        out_key_reg <= out_key_next;
        out_hdl_reg <= out_hdl_next;
        pos_reg     <= pos_next;
    end

    assign res_handle = out_hdl_reg;
    assign res_key    = out_key_reg;
    assign res_pos    = pos_reg;
    assign res_count  = count_reg;

endmodule

// ===== rtl/core/sorted_key_table_top.sv =====
// sorted key table, top level: entry ram, sequencer and result register
// depends on skt_pkg, skt_ram and skt_ctrl

// The table keeps up to DEPTH entries (signed 32-bit key plus handle) in ascending
// key order in a single ram of key and handle side by side. One item is worked
// on at a time; s_ready is high only while the sequencer is idle, and a finished
// result waits in the m_ register while the next item is taken. The search is a
// lower-bound binary search, each step one ram read and one compare. The accepting
// cycle and the search are followed by a probe read of the slot when it lies below
// the count and by the decision; insert then moves each entry at or after the slot
// up one place and writes the new entry, remove moves each entry after the slot
// down one place, and last the result is handed over. The worst case from one
// accepted item to the next is a remove at the front of a full table, set by the
// single read port of the entry ram that the search and the shift both go through.
// Ram contents are undefined after reset and need no clearing: only entries below
// the count are ever read.

module sorted_key_table_top #(
    parameter int DEPTH        = skt_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = skt_pkg::HANDLE_W_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [skt_pkg::ACT_W-1:0]        s_action,
    input  logic signed [skt_pkg::KEY_W-1:0] s_key,
    input  logic [HANDLE_WIDTH-1:0]          s_handle,
    input  logic [AW-1:0]                    s_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [skt_pkg::STATUS_W-1:0]     m_status,
    output logic [HANDLE_WIDTH-1:0]          m_handle_out,
    output logic signed [skt_pkg::KEY_W-1:0] m_key_out,
    output logic [CW-1:0]                    m_position,
    output logic [CW-1:0]                    m_count
);

    localparam int EW = skt_pkg::KEY_W + HANDLE_WIDTH;

    // ram ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    // result from the sequencer
    skt_pkg::res_ctl_t                res_ctl;
    logic [HANDLE_WIDTH-1:0]          res_handle;
    logic signed [skt_pkg::KEY_W-1:0] res_key;
    logic [CW-1:0]                    res_pos;
    logic [CW-1:0]                    res_count;
    logic                             res_free;

    // output register
    logic                             out_valid_reg, out_valid_next;
    skt_pkg::status_t                 out_status_reg;
    logic [HANDLE_WIDTH-1:0]          out_handle_reg;
    logic signed [skt_pkg::KEY_W-1:0] out_key_reg;
    logic [CW-1:0]                    out_pos_reg;
    logic [CW-1:0]                    out_count_reg;

    skt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skt_ctrl #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_action  (s_action),
        .in_key     (s_key),
        .in_handle  (s_handle),
        .in_index   (s_index),
        .res_ctl    (res_ctl),
        .res_handle (res_handle),
        .res_key    (res_key),
        .res_pos    (res_pos),
        .res_count  (res_count),
        .res_free   (res_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // the register is free when empty or being drained this cycle
    assign res_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ctl.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_ctl.valid) begin
            out_status_reg <= res_ctl.status;
            out_handle_reg <= res_handle;
            out_key_reg    <= res_key;
            out_pos_reg    <= res_pos;
            out_count_reg  <= res_count;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_handle_out = out_handle_reg;
    assign m_key_out    = out_key_reg;
    assign m_position   = out_pos_reg;
    assign m_count      = out_count_reg;

endmodule

// ===== rtl/core/skt_checker.sv =====
// port-level checks for the sorted key table, attached by bind
// depends on skt_pkg and sorted_key_table_top

module skt_checker #(
    parameter int DEPTH        = skt_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = skt_pkg::HANDLE_W_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [skt_pkg::STATUS_W-1:0]     m_status,
    input logic [HANDLE_WIDTH-1:0]          m_handle_out,
    input logic signed [skt_pkg::KEY_W-1:0] m_key_out,
    input logic [CW-1:0]                    m_position,
    input logic [CW-1:0]                    m_count
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_key_out)
            && $stable(m_handle_out) && $stable(m_position) && $stable(m_count))
    else $error("stalled result changed");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
    else $error("result valid after reset");

    // failed operations carry no entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != skt_pkg::STAT_OK |-> m_key_out == '0 && m_handle_out == '0)
    else $error("entry fields not zero on failed operation");

    // an index at or beyond the count reports position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == skt_pkg::STAT_RANGE |-> m_position == '0)
    else $error("range failure with nonzero position");

    // the table never holds more than its depth, and no position lies beyond the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= CW'(DEPTH) && m_position <= m_count)
    else $error("count or position beyond bounds");

endmodule

bind sorted_key_table_top skt_checker #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
) u_skt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_handle_out (m_handle_out),
    .m_key_out    (m_key_out),
    .m_position   (m_position),
    .m_count      (m_count)
);

// ===== bench/sorted_key_table_checker.sv =====
`timescale 1ns / 1ps
// result checker for the sorted key table: keeps a shadow table, predicts every result
// and compares it field by field; depends on skt_pkg

module sorted_key_table_checker #(
    parameter int DEPTH        = skt_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = skt_pkg::HANDLE_W_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [skt_pkg::ACT_W-1:0]        s_action,
    input  logic signed [skt_pkg::KEY_W-1:0] s_key,
    input  logic [HANDLE_WIDTH-1:0]          s_handle,
    input  logic [AW-1:0]                    s_index,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [skt_pkg::STATUS_W-1:0]     m_status,
    input  logic [HANDLE_WIDTH-1:0]          m_handle_out,
    input  logic signed [skt_pkg::KEY_W-1:0] m_key_out,
    input  logic [CW-1:0]                    m_position,
    input  logic [CW-1:0]                    m_count,
    output int                               fail_count,
    output int                               pending_results
);

    typedef struct packed {
        skt_pkg::status_t                 status;
        logic [HANDLE_WIDTH-1:0]          handle_out;
        logic [skt_pkg::KEY_W-1:0]        key_out;
        logic [CW-1:0]                    position;
        logic [CW-1:0]                    count;
    } table_result_t;

    logic signed [skt_pkg::KEY_W-1:0] shadow_keys [DEPTH];
    logic [HANDLE_WIDTH-1:0]          shadow_handles [DEPTH];
    int                               shadow_count;
    table_result_t                    awaited_results [$];
    int                               results_seen;

    // one table operation on the shadow copy, returning the result it must produce
    function automatic table_result_t apply_table_action(skt_pkg::action_t act,
                                                         logic signed [skt_pkg::KEY_W-1:0] k,
                                                         logic [HANDLE_WIDTH-1:0] h,
                                                         logic [AW-1:0] idx);
        table_result_t r;
        int lo, hi, mid, i;
        bit hit;
        r = '0;
        r.status = skt_pkg::STAT_OK;
        if (act == skt_pkg::ACT_GET) begin
            if (int'(idx) < shadow_count) begin
                r.position   = CW'(idx);
                r.handle_out = shadow_handles[idx];
                r.key_out    = shadow_keys[idx];
            end else begin
                r.status = skt_pkg::STAT_RANGE;
            end
        end else begin
            // lower bound by signed compare
            lo = 0;
            hi = shadow_count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (shadow_keys[mid] < k)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            hit = (lo < shadow_count) && (shadow_keys[lo] == k);
            r.position = CW'(lo);
            if (act == skt_pkg::ACT_INSERT) begin
                if (hit) begin
                    r.status = skt_pkg::STAT_DUP;
                end else if (shadow_count >= DEPTH) begin
                    r.status = skt_pkg::STAT_FULL;
                end else begin
                    for (i = shadow_count; i > lo; i--) begin
                        shadow_keys[i]    = shadow_keys[i-1];
                        shadow_handles[i] = shadow_handles[i-1];
                    end
                    shadow_keys[lo]    = k;
                    shadow_handles[lo] = h;
                    shadow_count++;
                    r.handle_out = h;
                    r.key_out    = k;
                end
            end else if (!hit) begin
                r.status = skt_pkg::STAT_MISS;
            end else begin
                r.handle_out = shadow_handles[lo];
                r.key_out    = shadow_keys[lo];
                if (act == skt_pkg::ACT_REMOVE) begin
                    for (i = lo; i < shadow_count - 1; i++) begin
                        shadow_keys[i]    = shadow_keys[i+1];
                        shadow_handles[i] = shadow_handles[i+1];
                    end
                    shadow_count--;
                end
            end
        end
        r.count = CW'(shadow_count);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: result %0d %s mismatch, expected %0h, got %0h",
                     $time, results_seen, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        table_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            // results first: a result leaving now belongs to an earlier item
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result %0d arrived with no item awaiting it",
                             $time, results_seen);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(m_status));
                    compare_field("handle_out", 64'(want.handle_out), 64'(m_handle_out));
                    compare_field("key_out", 64'(want.key_out), 64'($unsigned(m_key_out)));
                    compare_field("position", 64'(want.position), 64'(m_position));
                    compare_field("count", 64'(want.count), 64'(m_count));
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(apply_table_action(skt_pkg::action_t'(s_action),
                                                             s_key, s_handle, s_index));
        end
        pending_results = awaited_results.size();
    end

endmodule

// ===== bench/sorted_key_table_top_test.sv =====
`timescale 1ns / 1ps
// top of the sorted key table bench: clock, reset, item stimulus and the verdict
// depends on skt_pkg, sorted_key_table_top and sorted_key_table_checker

module sorted_key_table_top_test;

    localparam int DEPTH        = skt_pkg::DEPTH_DEF;
    localparam int HANDLE_WIDTH = skt_pkg::HANDLE_W_DEF;
    localparam int AW           = $clog2(DEPTH);
    localparam int CW           = $clog2(DEPTH + 1);

    localparam int RANDOM_ITEMS = 1250;
    // the limit covers a slow item plus the longest sink stall and sender gap
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TIME  = 120;
    // keys mostly come from a narrow window so that hits, duplicates and a full table occur
    localparam int KEY_SPAN     = 72;

    // traffic mixes for the random phases
    typedef enum int {
        MIX_FILL,
        MIX_LOOKUP,
        MIX_CHURN,
        MIX_DRAIN
    } traffic_mix_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    skt_pkg::action_t                   s_action;
    logic signed [skt_pkg::KEY_W-1:0]   s_key;
    logic [HANDLE_WIDTH-1:0]            s_handle;
    logic [AW-1:0]                      s_index;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [skt_pkg::STATUS_W-1:0]       m_status;
    logic [HANDLE_WIDTH-1:0]            m_handle_out;
    logic signed [skt_pkg::KEY_W-1:0]   m_key_out;
    logic [CW-1:0]                      m_position;
    logic [CW-1:0]                      m_count;

    int fail_count;
    int pending_results;
    int quiet_cycles = 0;
    int sink_cycles  = 0;
    int ready_hold   = 0;

    always #6 aclk = ~aclk;

    sorted_key_table_top #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_key        (s_key),
        .s_handle     (s_handle),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_handle_out (m_handle_out),
        .m_key_out    (m_key_out),
        .m_position   (m_position),
        .m_count      (m_count)
    );

    sorted_key_table_checker #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key           (s_key),
        .s_handle        (s_handle),
        .s_index         (s_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_handle_out    (m_handle_out),
        .m_key_out       (m_key_out),
        .m_position      (m_position),
        .m_count         (m_count),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // sink side: the stall style moves on in turn through three styles, paced by sink_cycles
    // style 0 never stalls, style 1 stalls briefly, style 2 holds off for long runs
    always @(negedge aclk) begin
        sink_cycles++;
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            case ((sink_cycles / 1024) % 3)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready    <= !m_ready;
                    ready_hold = m_ready ? $urandom_range(0, 2) : $urandom_range(0, 7);
                end
                default: begin
                    m_ready    <= !m_ready;
                    ready_hold = m_ready ? $urandom_range(0, 15) : $urandom_range(0, 39);
                end
            endcase
        end
    end

    // watchdog: too long without any item or result moving ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item at the falling edge and hold it until the block takes it
    task automatic send_item(skt_pkg::action_t act, logic signed [skt_pkg::KEY_W-1:0] k,
                             logic [HANDLE_WIDTH-1:0] h, logic [AW-1:0] idx);
        @(negedge aclk);
        s_action <= act;
        s_key    <= k;
        s_handle <= h;
        s_index  <= idx;
        s_valid  <= 1'b1;
        @(posedge aclk);
        while (!(s_valid && s_ready))
            @(posedge aclk);
    endtask

    // sender gap with valid low, its length set by n, n at least one
    task automatic sender_pause(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // hold the sender until every awaited result has come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
    endtask

    function automatic skt_pkg::action_t pick_action(traffic_mix_t mix);
        int roll, w_ins, w_fet, w_rem;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:   begin w_ins = 70; w_fet = 10; w_rem = 10; end
            MIX_LOOKUP: begin w_ins = 10; w_fet = 40; w_rem = 5;  end
            MIX_CHURN:  begin w_ins = 30; w_fet = 20; w_rem = 30; end
            default:    begin w_ins = 10; w_fet = 10; w_rem = 70; end
        endcase
        if (roll < w_ins)
            return skt_pkg::ACT_INSERT;
        if (roll < w_ins + w_fet)
            return skt_pkg::ACT_FETCH;
        if (roll < w_ins + w_fet + w_rem)
            return skt_pkg::ACT_REMOVE;
        return skt_pkg::ACT_GET;
    endfunction

    // mostly keys near zero, now and then a wild key or one at the ends of the range
    function automatic logic signed [skt_pkg::KEY_W-1:0] pick_key();
        int roll, near;
        roll = $urandom_range(0, 19);
        near = $urandom_range(0, KEY_SPAN - 1);
        case (roll)
            0:       return $urandom;
            1:       return 32'h8000_0000 | $urandom_range(0, 1);
            2:       return 32'h7fff_ffff - $urandom_range(0, 1);
            default: return near - KEY_SPAN / 2;
        endcase
    endfunction

    // half the reads anywhere in the index range, half near the bottom of the table
    function automatic logic [AW-1:0] pick_index();
        if ($urandom_range(0, 1) != 0)
            return AW'($urandom_range(0, DEPTH - 1));
        return AW'($urandom_range(0, 15));
    endfunction

    initial begin : stimulus
        traffic_mix_t mix;
        int random_sent, phase, phase_len, n, burst_left;
        random_sent = 0;
        phase       = 0;
        burst_left  = 0;

        // every input known from time zero
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_action = skt_pkg::ACT_INSERT;
        s_key    = '0;
        s_handle = '0;
        s_index  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table: get past the count, key misses on fetch and remove
        send_item(skt_pkg::ACT_GET,    $urandom, $urandom, AW'(0));
        send_item(skt_pkg::ACT_FETCH,  5,        $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_REMOVE, 5,        $urandom, AW'($urandom));
        // both ends of the key range and the sign boundary, handles at their extremes
        send_item(skt_pkg::ACT_INSERT, 32'sh7fff_ffff, 32'h0000_0000, AW'($urandom));
        send_item(skt_pkg::ACT_INSERT, 32'sh8000_0000, 32'hffff_ffff, AW'($urandom));
        send_item(skt_pkg::ACT_INSERT, 0,              32'ha5a5_a5a5, AW'($urandom));
        send_item(skt_pkg::ACT_INSERT, -1,             32'h5a5a_5a5a, AW'($urandom));
        // duplicate inserts leave the table alone
        send_item(skt_pkg::ACT_INSERT, 32'sh7fff_ffff, 32'h1234_5678, AW'($urandom));
        send_item(skt_pkg::ACT_INSERT, 0,              32'h8765_4321, AW'($urandom));
        // lookups at both ends and a miss that falls between entries
        send_item(skt_pkg::ACT_FETCH,  32'sh8000_0000, $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_FETCH,  32'sh7fff_ffff, $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_FETCH,  1,              $urandom, AW'($urandom));
        // reads at the first and last entry, at the count and at the top index
        send_item(skt_pkg::ACT_GET,    $urandom, $urandom, AW'(0));
        send_item(skt_pkg::ACT_GET,    $urandom, $urandom, AW'(3));
        send_item(skt_pkg::ACT_GET,    $urandom, $urandom, AW'(4));
        send_item(skt_pkg::ACT_GET,    $urandom, $urandom, AW'(DEPTH - 1));
        // removal from the middle, the front and the back, then a miss
        send_item(skt_pkg::ACT_REMOVE, -1,             $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_REMOVE, 32'sh8000_0000, $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_REMOVE, 32'sh7fff_ffff, $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_REMOVE, 7,              $urandom, AW'($urandom));
        // last entry out, table back to empty
        send_item(skt_pkg::ACT_FETCH,  0, $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_REMOVE, 0, $urandom, AW'($urandom));
        send_item(skt_pkg::ACT_GET,    $urandom, $urandom, AW'(0));
        wait_for_results();

        // random phases: fill to full, look up, churn, drain, and round again
        while (random_sent < RANDOM_ITEMS) begin
            mix       = traffic_mix_t'(phase % 4);
            phase_len = (mix == MIX_FILL) ? $urandom_range(220, 280) : $urandom_range(120, 260);
            for (n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
                // bursts of random length, about a third of them back to back
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 2) != 0)
                        sender_pause($urandom_range(1, 15));
                end
                burst_left--;
                send_item(pick_action(mix), pick_key(), $urandom, pick_index());
                random_sent++;
            end
            // let the block run dry every other phase
            if (phase % 2 == 1)
                wait_for_results();
            phase++;
        end

        wait_for_results();
        repeat (SETTLE_TIME) @(posedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table_top.sv
rtl/core/skt_checker.sv
bench/sorted_key_table_checker.sv
bench/sorted_key_table_top_test.sv
